[hdl/bsdq_pkg.sv]
// ----------------------------------------------------------------------------
// bsdq_pkg : shared types of the bounded sequence deque store
// Opcode and status codes carried on the item and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_REVERSE    = 3'd5,
        OP_REMOVE_NTH = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_BADPOS   = 3'd4
    } t_status;

endpackage

`default_nettype wire

[hdl/bsdq_ram.sv]
// ----------------------------------------------------------------------------
// bsdq_ram : generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/bounded_sequence_deque_store_core.sv]
// ----------------------------------------------------------------------------
// bounded_sequence_deque_store_core : deque of 32-bit words with search/remove
// Push, pop, reverse and rejected ops go straight from idle to the done state.
// Search and remove-nth step through the stored entries, one store entry per
// cycle through the single RAM read port. One item at a time:
// the next beat is taken the cycle after the result is issued.
// Reset clears pointer, count and reversed flag; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sequence_deque_store_core
    import bsdq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_opcode,
    input  wire logic signed [31:0] i_value,
    input  wire logic [CW-1:0]      i_position,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_status,
    output logic [AW-1:0]           o_found_index,
    output logic [CW-1:0]           o_occupancy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_front;
    logic [CW-1:0] r_count;
    logic          r_rev;
    logic [CW-1:0] r_idx;
    logic          r_chk;
    logic [AW-1:0] r_tag;
    logic [31:0]   r_key;
    t_status       r_res_status;
    logic [AW-1:0] r_res_found;
    logic          r_out_vld;
    t_status       r_status;
    logic [AW-1:0] r_found;
    logic [CW-1:0] r_occ;

    t_opcode       w_op;
    logic          w_acc;
    logic          w_full;
    logic          w_empty;
    logic          w_push_low;
    logic          w_pop_low;
    logic [AW-1:0] w_front_dec;
    logic [AW-1:0] w_front_inc;
    logic [CW-1:0] w_idx_inc;
    logic [CW-1:0] w_rev_idx;
    logic [CW-1:0] w_rm_off;
    logic [AW-1:0] w_off;
    logic [AW-1:0] w_slot;
    logic [AW-1:0] w_slot_cur;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [31:0]   w_wd;
    logic [31:0]   w_rd_data;

    // physical slot of an offset from the low end of the circular store
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, front} + {1'b0, off};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_op        = t_opcode'(i_opcode);
    assign w_acc       = i_in_valid && (r_state == S_IDLE);
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_push_low  = (w_op == OP_PUSH_FRONT) ^ r_rev;
    assign w_pop_low   = (w_op == OP_POP_FRONT) ^ r_rev;
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign w_idx_inc   = r_idx + CW'(1);
    assign w_rev_idx   = r_count - r_idx - CW'(1);
    assign w_rm_off    = r_rev ? (i_position - CW'(1)) : (r_count - i_position);

    // offset for the shared slot adder
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_off = r_count[AW-1:0];
            S_SRCH:  w_off = r_rev ? w_rev_idx[AW-1:0] : r_idx[AW-1:0];
            S_SHIFT: w_off = w_idx_inc[AW-1:0];
            S_DONE:  w_off = '0;
            default: w_off = '0;
        endcase
    end

    assign w_slot     = slot_of(r_front, w_off);
    assign w_slot_cur = slot_of(r_front, r_idx[AW-1:0]);

    always_comb begin
        w_we = 1'b0;
        w_wa = w_slot;
        w_wd = i_value;
        if (w_acc && (w_op == OP_PUSH_FRONT || w_op == OP_PUSH_BACK) && !w_full) begin
            w_we = 1'b1;
            w_wa = w_push_low ? w_front_dec : w_slot;
        end else if (r_state == S_SHIFT && r_chk) begin
            // close the gap: the entry read last cycle moves down one slot
            w_we = 1'b1;
            w_wa = r_tag;
            w_wd = w_rd_data;
        end
    end

    bsdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wa),
        .i_wdata (w_wd),
        .i_raddr (w_slot),
        .o_rdata (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_rev     <= 1'b0;
            r_chk     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // drop the result beat once taken, unless a new one is loaded
            if (r_out_vld && !i_out_stall && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_res_status <= ST_OK;
                        r_res_found  <= '0;
                        r_state      <= S_DONE;
                        unique case (w_op)
                            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                                if (w_full) begin
                                    r_res_status <= ST_FULL;
                                end else begin
                                    if (w_push_low) begin
                                        r_front <= w_front_dec;
                                    end
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            OP_POP_FRONT, OP_POP_BACK: begin
                                if (w_empty) begin
                                    r_res_status <= ST_EMPTY;
                                end else begin
                                    if (w_pop_low) begin
                                        r_front <= w_front_inc;
                                    end
                                    r_count <= r_count - CW'(1);
                                end
                            end
                            OP_SEARCH: begin
                                r_key   <= i_value;
                                r_idx   <= '0;
                                r_chk   <= 1'b0;
                                r_state <= S_SRCH;
                            end
                            OP_REVERSE: begin
                                r_rev <= ~r_rev;
                            end
                            OP_REMOVE_NTH: begin
                                if (w_empty) begin
                                    r_res_status <= ST_EMPTY;
                                end else if (i_position == '0 || i_position > r_count) begin
                                    r_res_status <= ST_BADPOS;
                                end else begin
                                    r_idx   <= w_rm_off;
                                    r_chk   <= 1'b0;
                                    r_state <= S_SHIFT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SRCH: begin
                    // compare the entry read last cycle, issue the next read
                    if (r_chk && w_rd_data == r_key) begin
                        r_res_found <= r_tag;
                        r_chk       <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (r_idx == r_count) begin
                        r_res_status <= ST_NOTFOUND;
                        r_chk        <= 1'b0;
                        r_state      <= S_DONE;
                    end else begin
                        r_chk <= 1'b1;
                        r_tag <= r_idx[AW-1:0];
                        r_idx <= w_idx_inc;
                    end
                end
                S_SHIFT: begin
                    if (w_idx_inc < r_count) begin
                        r_chk <= 1'b1;
                        r_tag <= w_slot_cur;
                        r_idx <= w_idx_inc;
                    end else begin
                        r_chk   <= 1'b0;
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld <= 1'b1;
                        r_status  <= r_res_status;
                        r_found   <= r_res_found;
                        r_occ     <= r_count;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_occupancy   = r_occ;

endmodule

`default_nettype wire

[bench/bounded_sequence_deque_store_core_tb.sv]
// ----------------------------------------------------------------------------
// bounded_sequence_deque_store_core_tb : self-checking bench for the deque core
// Walks a short table of edge cases, then ~1600 random operations with biased
// fill and drain phases. A shadow deque predicts status, index and occupancy
// for every accepted beat. Both sides idle and stall at random outside a calm stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_sequence_deque_store_core_tb;
    import bsdq_pkg::*;

    localparam int         DEPTH        = 16;
    localparam int         RANDOM_BEATS = 1600;
    localparam logic [2:0] OP_UNUSED    = 3'd7;

    typedef struct packed {
        t_status    status;
        logic [3:0] found_index;
        logic [4:0] occupancy;
    } t_outcome;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] val;
        logic [4:0]  pos;
        logic [4:0]  reps;
        logic        typed;
        t_status     st;
        logic [3:0]  idx;
        logic [4:0]  occ;
    } t_script_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [2:0]         i_opcode      = '0;
    logic signed [31:0] i_value       = '0;
    logic [4:0]         i_position    = '0;
    logic               i_out_stall   = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [2:0]         o_status;
    logic [3:0]         o_found_index;
    logic [4:0]         o_occupancy;

    // shadow copy of the deque
    logic [31:0] shadow_words [DEPTH];
    logic [3:0]  shadow_low     = '0;
    int          shadow_held    = 0;
    bit          shadow_flipped = 1'b0;

    t_outcome pending_results [$];
    int       mismatches = 0;
    bit       calm       = 1'b0;

    bounded_sequence_deque_store_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_occupancy   (o_occupancy)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [3:0] slot_of(int off);
        return 4'(shadow_low + off);
    endfunction

    function automatic int offset_of_index(int idx);
        return shadow_flipped ? shadow_held - 1 - idx : idx;
    endfunction

    task automatic deque_predict(input logic [2:0] op, input logic [31:0] val,
                                 input logic [4:0] pos, output t_outcome res);
        bit at_low;
        int off;
        res.status      = ST_OK;
        res.found_index = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_held >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    at_low = (op == OP_PUSH_FRONT) ^ shadow_flipped;
                    if (at_low) begin
                        shadow_low = shadow_low - 4'd1;
                        shadow_words[shadow_low] = val;
                    end else begin
                        shadow_words[slot_of(shadow_held)] = val;
                    end
                    shadow_held++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    at_low = (op == OP_POP_FRONT) ^ shadow_flipped;
                    if (at_low)
                        shadow_low = shadow_low + 4'd1;
                    shadow_held--;
                end
            end
            OP_SEARCH: begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < shadow_held; i++) begin
                    if (res.status == ST_NOTFOUND &&
                        shadow_words[slot_of(offset_of_index(i))] == val) begin
                        res.status      = ST_OK;
                        res.found_index = 4'(i);
                    end
                end
            end
            OP_REVERSE: begin
                shadow_flipped = !shadow_flipped;
            end
            OP_REMOVE_NTH: begin
                if (shadow_held == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos == 0 || pos > shadow_held) begin
                    res.status = ST_BADPOS;
                end else begin
                    // close the gap towards the low end
                    off = offset_of_index(shadow_held - pos);
                    for (int j = off; j + 1 < shadow_held; j++)
                        shadow_words[slot_of(j)] = shadow_words[slot_of(j + 1)];
                    shadow_held--;
                end
            end
            default: ;
        endcase
        res.occupancy = 5'(shadow_held);
    endtask

    task automatic send_beat(input logic [2:0] op, input logic [31:0] val,
                             input logic [4:0] pos, input bit typed,
                             input t_outcome typed_res);
        t_outcome res;
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        deque_predict(op, val, pos, res);
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
    endtask

    task automatic check_result();
        t_outcome want;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: status %0d occupancy %0d",
                   o_status, o_occupancy);
            mismatches++;
        end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (o_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, o_status);
                mismatches++;
            end
            if (o_found_index !== want.found_index) begin
                $error("found_index: expected %0d, got %0d",
                       want.found_index, o_found_index);
                mismatches++;
            end
            if (o_occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_result();
            i_out_stall <= !calm && ($urandom_range(0, 99) < 30);
        end
    end

    initial begin : stimulus
        t_script_row script [29];
        t_outcome    typed_res;
        logic [2:0]  op;
        logic [31:0] val;
        logic [4:0]  pos;
        int          pick;
        int          push_bias;

        script = '{
            '{OP_POP_FRONT,  32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_EMPTY,    4'd0, 5'd0},
            '{OP_POP_BACK,   32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_EMPTY,    4'd0, 5'd0},
            '{OP_SEARCH,     32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_NOTFOUND, 4'd0, 5'd0},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd1,  5'd1,  1'b1, ST_EMPTY,    4'd0, 5'd0},
            '{OP_REVERSE,    32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd0},
            '{OP_REVERSE,    32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd0},
            '{OP_UNUSED,     32'hffff_ffff, 5'd31, 5'd1,  1'b1, ST_OK,       4'd0, 5'd0},
            '{OP_PUSH_BACK,  32'h7fff_ffff, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd1},
            '{OP_PUSH_FRONT, 32'h8000_0000, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd2},
            '{OP_PUSH_BACK,  32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd3},
            '{OP_PUSH_BACK,  32'hffff_ffff, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd4},
            '{OP_SEARCH,     32'hffff_ffff, 5'd0,  5'd1,  1'b1, ST_OK,       4'd3, 5'd4},
            '{OP_SEARCH,     32'h8000_0000, 5'd0,  5'd1,  1'b1, ST_OK,       4'd0, 5'd4},
            '{OP_SEARCH,     32'h0001_2345, 5'd0,  5'd1,  1'b1, ST_NOTFOUND, 4'd0, 5'd4},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd0,  5'd1,  1'b1, ST_BADPOS,   4'd0, 5'd4},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd5,  5'd1,  1'b1, ST_BADPOS,   4'd0, 5'd4},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd31, 5'd1,  1'b1, ST_BADPOS,   4'd0, 5'd4},
            '{OP_REVERSE,    32'h0000_0000, 5'd0,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_SEARCH,     32'hffff_ffff, 5'd0,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd1,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_PUSH_FRONT, 32'h0000_0100, 5'd0,  5'd13, 1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_PUSH_BACK,  32'h5a5a_5a5a, 5'd0,  5'd1,  1'b1, ST_FULL,     4'd0, 5'd16},
            '{OP_PUSH_FRONT, 32'ha5a5_a5a5, 5'd0,  5'd1,  1'b1, ST_FULL,     4'd0, 5'd16},
            '{OP_SEARCH,     32'h7fff_ffff, 5'd0,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd16, 5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_REMOVE_NTH, 32'h0000_0000, 5'd1,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_POP_FRONT,  32'h0000_0000, 5'd0,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_POP_BACK,   32'h0000_0000, 5'd0,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0},
            '{OP_SEARCH,     32'h0000_0105, 5'd0,  5'd1,  1'b0, ST_OK,       4'd0, 5'd0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                typed_res.status      = script[r].st;
                typed_res.found_index = script[r].idx;
                typed_res.occupancy   = script[r].occ;
                send_beat(script[r].op, script[r].val + 32'(k), script[r].pos,
                          script[r].typed, typed_res);
            end
        end

        push_bias = 50;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // swing between fill and drain phases so both ends get exercised
            if (n % 100 == 0)
                push_bias = $urandom_range(15, 85);
            calm = (n >= 300 && n < 500);
            if (n == 800) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end

            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // small key pool so duplicates and search hits are common
                val = 32'($urandom_range(0, 7));
            end else if (pick < 50) begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h0000_0000;
                    1:       val = 32'hffff_ffff;
                    2:       val = 32'h8000_0000;
                    default: val = 32'h7fff_ffff;
                endcase
            end else begin
                val = $urandom;
            end
            pos = 5'($urandom_range(0, 31));

            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                op = OP_SEARCH;
                if (shadow_held > 0 && $urandom_range(0, 99) < 65)
                    val = shadow_words[slot_of($urandom_range(0, shadow_held - 1))];
            end else if (pick < 17) begin
                op = OP_REVERSE;
            end else if (pick < 28) begin
                op = OP_REMOVE_NTH;
                if ($urandom_range(0, 99) < 75)
                    pos = 5'($urandom_range(1, shadow_held > 0 ? shadow_held : 1));
            end else if (pick < 30) begin
                op = OP_UNUSED;
            end else if ($urandom_range(0, 99) < push_bias) begin
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            send_beat(op, val, pos, 1'b0, '0);
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
